@@ src/p2g_pkg.sv @@
package p2g_pkg;

  localparam int unsigned GRID_DEPTH = 4096;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned SUM_W      = 48;

  localparam int unsigned DEF_MAX_CELLS_X  = 63;
  localparam int unsigned DEF_MAX_CELLS_Y  = 63;
  localparam int unsigned DEF_STENCIL_SPAN = 7;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_INV_X    = 3'd2;
  localparam logic [2:0] CFG_INV_Y    = 3'd3;
  localparam logic [2:0] CFG_CELLS_X  = 3'd4;
  localparam logic [2:0] CFG_CELLS_Y  = 3'd5;
  localparam logic [2:0] CFG_SLOPE_X  = 3'd6;
  localparam logic [2:0] CFG_SLOPE_Y  = 3'd7;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [23:0]        inv_x;
    logic [23:0]        inv_y;
    logic [5:0]         ncx;
    logic [5:0]         ncy;
    logic               slope_x;
    logic               slope_y;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              mul;
    logic              issue;
    logic [1:0]        ix;
    logic [1:0]        iy;
    logic              rd_issue;
    logic              rd_data;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } sts_t;

endpackage

@@ src/p2g_ram.sv @@
module p2g_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/p2g_ctrl.sv @@
module p2g_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            action_i,
  output logic            in_ready_o,
  input  p2g_pkg::sts_t   sts_i,
  output p2g_pkg::cmd_t   cmd_o
);
  import p2g_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_MUL     = 3'd2;
  localparam logic [2:0] ST_ISSUE   = 3'd3;
  localparam logic [2:0] ST_DRAIN   = 3'd4;
  localparam logic [2:0] ST_RD_REQ  = 3'd5;
  localparam logic [2:0] ST_RD_DATA = 3'd6;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_DEPTH - 1);

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [1:0]        ix_q, ix_d, iy_q, iy_d;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    ix_d         = ix_q;
    iy_d         = iy_q;
    cmd_o        = '0;
    cmd_o.ix     = ix_q;
    cmd_o.iy     = iy_q;
    cmd_o.clr_addr = clr_q;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = action_i ? ST_RD_REQ : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        ix_d = 2'd0;
        iy_d = 2'd0;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (iy_q == 2'd2) begin
          iy_d = 2'd0;
          ix_d = ix_q + 1'b1;
          if (ix_q == 2'd2) begin
            state_d = ST_DRAIN;
          end
        end else begin
          iy_d = iy_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_REQ: begin
        if (sts_i.out_free) begin
          cmd_o.rd_issue = 1'b1;
          state_d = ST_RD_DATA;
        end
      end
      ST_RD_DATA: begin
        cmd_o.rd_data = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ix_q    <= '0;
      iy_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ix_q    <= ix_d;
      iy_q    <= iy_d;
    end
  end

endmodule

@@ src/p2g_dp.sv @@
module p2g_dp #(
  parameter int unsigned STENCIL_SPAN = p2g_pkg::DEF_STENCIL_SPAN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  p2g_pkg::cfg_t        cfg_i,
  input  p2g_pkg::cmd_t        cmd_i,
  output p2g_pkg::sts_t        sts_o,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   particle_value_i,
  input  logic [11:0]          node_index_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic signed [47:0]   node_value_o,
  output logic [11:0]          node_addr_o
);
  import p2g_pkg::*;

  localparam int SpanLo = -((int'(STENCIL_SPAN) - 1) / 2);
  localparam int SpanHi = SpanLo + int'(STENCIL_SPAN) - 1;

  localparam logic [1:0] RG_ZERO  = 2'd0;
  localparam logic [1:0] RG_INNER = 2'd1;
  localparam logic [1:0] RG_OUTER = 2'd2;

  localparam logic signed [58:0] SUM_MAX = 59'sd140737488355327;
  localparam logic signed [58:0] SUM_MIN = -59'sd140737488355328;

  // node offset from the base cell: the three nodes that can carry weight
  function automatic logic signed [2:0] node_off(logic [15:0] f, logic [1:0] i);
    node_off = (f > 16'd32768) ? $signed({1'b0, i}) : $signed({1'b0, i} - 3'd1);
  endfunction

  function automatic logic [1:0] region(logic signed [19:0] d);
    logic [19:0] a;
    a = d[19] ? 20'(-d) : 20'(d);
    if (a < 20'd32768) begin
      region = RG_INNER;
    end else if (a < 20'd98304) begin
      region = RG_OUTER;
    end else begin
      region = RG_ZERO;
    end
  endfunction

  // multiplier operand for the spline value (squared) or slope (times inv)
  function automatic logic signed [19:0] spl_op(logic signed [19:0] d, logic slope);
    logic signed [19:0] a;
    a = d[19] ? -d : d;
    if (a < 20'sd32768) begin
      spl_op = slope ? -d : a;
    end else if (slope && !d[19] && d != 20'sd0) begin
      spl_op = a - 20'sd98304;
    end else begin
      spl_op = 20'sd98304 - a;
    end
  endfunction

  function automatic logic signed [31:0] to_q20(logic signed [44:0] p, logic [1:0] rg,
                                               logic slope);
    logic signed [45:0] t;
    t = '0;
    case (rg)
      RG_INNER: begin
        if (slope) begin
          t = (46'(p) + 46'sd1024) >>> 11;
        end else begin
          t = (46'sd6442450944 - (46'(p) <<< 1) + 46'sd4096) >>> 13;
        end
      end
      RG_OUTER: begin
        if (slope) begin
          t = (46'(p) + 46'sd2048) >>> 12;
        end else begin
          t = (46'(p) + 46'sd4096) >>> 13;
        end
      end
      default: t = '0;
    endcase
    to_q20 = 32'(t);
  endfunction

  // per-item registers
  logic signed [32:0] dx_q, dy_q;
  logic signed [31:0] val_q;
  logic [ADDR_W-1:0]  idx_q;
  logic signed [25:0] bx_q, by_q;
  logic [15:0]        fx_q, fy_q;

  // node pipeline
  logic [7:1]         v_q;
  logic [ADDR_W-1:0]  addr_q [1:7];
  logic signed [19:0] d1x_q, d1y_q;
  logic [1:0]         r2x_q, r2y_q;
  logic signed [44:0] p2x_q, p2y_q;
  logic signed [31:0] w3x_q, w3y_q;
  logic signed [63:0] wxy4_q;
  logic signed [47:0] w5_q;
  logic signed [57:0] pl6_q;
  logic signed [23:0] wh6_q;
  logic signed [57:0] c7_q;

  logic               out_valid_q;
  logic signed [47:0] out_value_q;
  logic [ADDR_W-1:0]  out_addr_q;

  logic signed [57:0] prod_x, prod_y;
  logic signed [2:0]  ox, oy;
  logic signed [26:0] kx, ky;
  logic signed [19:0] dx0, dy0;
  logic [6:0]         rows;
  logic [12:0]        addr0;
  logic               live0;
  logic signed [24:0] opbx, opby;
  logic signed [19:0] mx, my;
  logic signed [58:0] sum;
  logic signed [47:0] sat;
  logic [SUM_W-1:0]   rdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [SUM_W-1:0]   ram_wdata;

  assign prod_x = dx_q * $signed({1'b0, cfg_i.inv_x});
  assign prod_y = dy_q * $signed({1'b0, cfg_i.inv_y});

  always_comb begin
    ox    = node_off(fx_q, cmd_i.ix);
    oy    = node_off(fy_q, cmd_i.iy);
    kx    = $signed({bx_q[25], bx_q}) + $signed({{24{ox[2]}}, ox});
    ky    = $signed({by_q[25], by_q}) + $signed({{24{oy[2]}}, oy});
    dx0   = $signed({4'b0000, fx_q}) - $signed({ox[2], ox, 16'h0000});
    dy0   = $signed({4'b0000, fy_q}) - $signed({oy[2], oy, 16'h0000});
    rows  = {1'b0, cfg_i.ncy} + 7'd1;
    addr0 = 13'(kx[5:0]) * 13'(rows) + 13'(ky[5:0]);
    live0 = cmd_i.issue
          && !kx[26] && (kx <= $signed({21'b0, cfg_i.ncx}))
          && !ky[26] && (ky <= $signed({21'b0, cfg_i.ncy}))
          && (int'(ox) >= SpanLo) && (int'(ox) <= SpanHi)
          && (int'(oy) >= SpanLo) && (int'(oy) <= SpanHi)
          && (addr0 < 13'(GRID_DEPTH));
  end

  always_comb begin
    mx   = spl_op(d1x_q, cfg_i.slope_x);
    my   = spl_op(d1y_q, cfg_i.slope_y);
    opbx = cfg_i.slope_x ? $signed({1'b0, cfg_i.inv_x}) : 25'(mx);
    opby = cfg_i.slope_y ? $signed({1'b0, cfg_i.inv_y}) : 25'(my);
  end

  // saturating update of the stored sum
  always_comb begin
    sum = $signed({{11{rdata[SUM_W-1]}}, rdata}) + 59'(c7_q);
    if (sum > SUM_MAX) begin
      sat = 48'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      sat = 48'(SUM_MIN);
    end else begin
      sat = 48'(sum);
    end
  end

  always_comb begin
    ram_raddr = cmd_i.rd_issue ? idx_q : addr_q[6];
    ram_we    = cmd_i.clr_we || cmd_i.rd_data || v_q[7];
    ram_wdata = '0;
    ram_waddr = addr_q[7];
    if (cmd_i.clr_we) begin
      ram_waddr = cmd_i.clr_addr;
    end else if (cmd_i.rd_data) begin
      ram_waddr = idx_q;
    end else begin
      ram_wdata = sat;
    end
  end

  p2g_ram #(
    .Width (SUM_W),
    .Depth (GRID_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q  <= $signed({pos_x_i[31], pos_x_i}) - $signed({cfg_i.origin_x[31], cfg_i.origin_x});
      dy_q  <= $signed({pos_y_i[31], pos_y_i}) - $signed({cfg_i.origin_y[31], cfg_i.origin_y});
      val_q <= particle_value_i;
      idx_q <= node_index_i;
    end
    if (cmd_i.mul) begin
      bx_q <= prod_x[57:32];
      fx_q <= prod_x[31:16];
      by_q <= prod_y[57:32];
      fy_q <= prod_y[31:16];
    end
    addr_q[1] <= addr0[ADDR_W-1:0];
    for (int s = 2; s <= 7; s++) begin
      addr_q[s] <= addr_q[s-1];
    end
    d1x_q  <= dx0;
    d1y_q  <= dy0;
    r2x_q  <= region(d1x_q);
    r2y_q  <= region(d1y_q);
    p2x_q  <= mx * opbx;
    p2y_q  <= my * opby;
    w3x_q  <= to_q20(p2x_q, r2x_q, cfg_i.slope_x);
    w3y_q  <= to_q20(p2y_q, r2y_q, cfg_i.slope_y);
    wxy4_q <= w3x_q * w3y_q;
    w5_q   <= 48'((wxy4_q + 64'sd32768) >>> 16);
    pl6_q  <= val_q * $signed({1'b0, w5_q[23:0]});
    wh6_q  <= w5_q[47:24];
    c7_q   <= 58'(val_q * wh6_q) + ((pl6_q + 58'sd8388608) >>> 24);
    if (cmd_i.rd_data) begin
      out_value_q <= $signed(rdata);
      out_addr_q  <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v_q <= {v_q[6:1], live0};
      if (cmd_i.rd_data) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.busy     = |v_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign node_value_o   = out_value_q;
  assign node_addr_o    = out_addr_q;

`ifndef SYNTHESIS
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v_q[7] && (cmd_i.clr_we || cmd_i.rd_data)))
    else $error("node write collides with clear or read write");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_data |-> !out_valid_q)
    else $error("read result lands on an occupied output register");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(|v_q))
    else $error("item accepted while node pipeline still busy");
`endif

endmodule

@@ src/particle_to_grid_bspline_scatter_unit.sv @@
// particle-to-grid scatter, quadratic b-spline weights, 2d node grid
// input channel (in_valid_i / in_ready_o): action_i = 0 deposits a particle,
// action_i = 1 reads one node sum at node_index_i and clears it
// output channel (out_valid_o / out_ready_i): one transfer per read item,
// node_value_o with node_addr_o; deposits give no result
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i, which the user
// must do only while idle; the block does not enforce it. deposit: the
// position multiply, nine node issues into a seven-stage weight pipeline
// whose last stage does the read-modify-write on the single-write-port node
// memory, then the drain. read: issued once the output register is free; the
// result is registered and the entry cleared, then the next item is accepted
// reset: a clearing pass writes zero to all 4096 node entries, one per
// cycle, with in_ready_o low; config writes are taken during the pass
// a stalled receiver holds the result in the output register; a further
// item is still accepted, and a read then waits for the register to free
module particle_to_grid_bspline_scatter_unit #(
  parameter int unsigned MAX_CELLS_X  = p2g_pkg::DEF_MAX_CELLS_X,
  parameter int unsigned MAX_CELLS_Y  = p2g_pkg::DEF_MAX_CELLS_Y,
  parameter int unsigned STENCIL_SPAN = p2g_pkg::DEF_STENCIL_SPAN
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] particle_value_i,
  input  logic [11:0]        node_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] node_value_o,
  output logic [11:0]        node_addr_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import p2g_pkg::*;

  logic signed [31:0] origin_x_q, origin_y_q;
  logic [23:0]        inv_x_q, inv_y_q;
  logic [5:0]         cells_x_q, cells_y_q;
  logic               slope_x_q, slope_y_q;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_x_q    <= 24'd65536;
      inv_y_q    <= 24'd65536;
      cells_x_q  <= 6'd63;
      cells_y_q  <= 6'd63;
      slope_x_q  <= 1'b0;
      slope_y_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_INV_X:    inv_x_q    <= cfg_data_i[23:0];
        CFG_INV_Y:    inv_y_q    <= cfg_data_i[23:0];
        CFG_CELLS_X:  cells_x_q  <= cfg_data_i[5:0];
        CFG_CELLS_Y:  cells_y_q  <= cfg_data_i[5:0];
        CFG_SLOPE_X:  slope_x_q  <= cfg_data_i[0];
        CFG_SLOPE_Y:  slope_y_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // cell counts limited to the grid size the build supports
  always_comb begin
    cfg.origin_x = origin_x_q;
    cfg.origin_y = origin_y_q;
    cfg.inv_x    = inv_x_q;
    cfg.inv_y    = inv_y_q;
    cfg.ncx      = (int'(cells_x_q) > int'(MAX_CELLS_X)) ? 6'(MAX_CELLS_X) : cells_x_q;
    cfg.ncy      = (int'(cells_y_q) > int'(MAX_CELLS_Y)) ? 6'(MAX_CELLS_Y) : cells_y_q;
    cfg.slope_x  = slope_x_q;
    cfg.slope_y  = slope_y_q;
  end

  p2g_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  p2g_dp #(
    .STENCIL_SPAN (STENCIL_SPAN)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .particle_value_i (particle_value_i),
    .node_index_i     (node_index_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .node_value_o     (node_value_o),
    .node_addr_o      (node_addr_o)
  );

endmodule
